// ----- rtl/core/rmc_pkg.sv -----
// rmc_pkg: shared types and constants for the rmc sentence field extractor
// no dependencies

package rmc_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [2:0] ID_LEN      = 3'd6;
   localparam logic [2:0] ID_MAX      = 3'd7;
   localparam logic [3:0] COMMA_MAX   = 4'd15;

   localparam logic [3:0] COMMA_LAT    = 4'd3;
   localparam logic [3:0] COMMA_LON    = 4'd5;
   localparam logic [3:0] COMMA_SPEED  = 4'd7;
   localparam logic [3:0] COMMA_COURSE = 4'd8;

   localparam logic [1:0] FIELD_LAT    = 2'd0;
   localparam logic [1:0] FIELD_LON    = 2'd1;
   localparam logic [1:0] FIELD_SPEED  = 2'd2;
   localparam logic [1:0] FIELD_COURSE = 2'd3;

   typedef struct packed {
      logic [1:0] field_id;
      logic [3:0] char_pos;
      logic [7:0] char_value;
      logic       has_char;
      logic       done_res;
   } result_type;

   // expected identifier "$GNRMC", one character per index
   function automatic logic [7:0] wanted_id(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h47;
         3'd2:    ch = 8'h4E;
         3'd3:    ch = 8'h52;
         3'd4:    ch = 8'h4D;
         3'd5:    ch = 8'h43;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ----- rtl/core/rmc_parse_core.sv -----
// rmc_parse_core: sentence parser state and per-byte next-state logic
// depends on rmc_pkg

module rmc_parse_core #(
   parameter int LAT_CHARS    = 10,
   parameter int LON_CHARS    = 11,
   parameter int SPEED_CHARS  = 5,
   parameter int COURSE_CHARS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_accept,
   input  logic [7:0]          rx_byte,
   output logic                res_valid,
   output rmc_pkg::result_type res
);

   localparam logic [1:0] MODE_HUNT   = 2'd0;
   localparam logic [1:0] MODE_ID     = 2'd1;
   localparam logic [1:0] MODE_FIELDS = 2'd2;

   localparam logic [3:0] LAT_LIM    = 4'(LAT_CHARS);
   localparam logic [3:0] LON_LIM    = 4'(LON_CHARS);
   localparam logic [3:0] SPEED_LIM  = 4'(SPEED_CHARS);
   localparam logic [3:0] COURSE_LIM = 4'(COURSE_CHARS);

   logic [1:0] mode_ff, mode_in;
   logic [2:0] id_index_ff, id_index_in;
   logic       mismatch_ff, mismatch_in;
   logic [3:0] comma_ff, comma_in;
   logic [3:0] pos_ff, pos_in;

   logic       in_field;
   logic [1:0] field_code;
   logic [3:0] field_limit;

   always_comb begin
      in_field    = 1'b1;
      field_code  = rmc_pkg::FIELD_LAT;
      field_limit = LAT_LIM;
      unique case (comma_ff)
         rmc_pkg::COMMA_LAT: begin
            field_code  = rmc_pkg::FIELD_LAT;
            field_limit = LAT_LIM;
         end
         rmc_pkg::COMMA_LON: begin
            field_code  = rmc_pkg::FIELD_LON;
            field_limit = LON_LIM;
         end
         rmc_pkg::COMMA_SPEED: begin
            field_code  = rmc_pkg::FIELD_SPEED;
            field_limit = SPEED_LIM;
         end
         rmc_pkg::COMMA_COURSE: begin
            field_code  = rmc_pkg::FIELD_COURSE;
            field_limit = COURSE_LIM;
         end
         default: in_field = 1'b0;
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      id_index_in = id_index_ff;
      mismatch_in = mismatch_ff;
      comma_in    = comma_ff;
      pos_in      = pos_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (rx_byte == rmc_pkg::CHAR_DOLLAR) begin
         mode_in     = MODE_ID;
         id_index_in = 3'd1;
         mismatch_in = 1'b0;
         comma_in    = '0;
         pos_in      = '0;
      end else begin
         unique case (mode_ff)
            MODE_ID: begin
               if (rx_byte == rmc_pkg::CHAR_COMMA) begin
                  if (id_index_ff == rmc_pkg::ID_LEN && !mismatch_ff) begin
                     mode_in  = MODE_FIELDS;
                     comma_in = 4'd1;
                     pos_in   = '0;
                  end else begin
                     mode_in     = MODE_HUNT;
                     id_index_in = '0;
                     mismatch_in = 1'b0;
                     comma_in    = '0;
                     pos_in      = '0;
                  end
               end else begin
                  if (id_index_ff >= rmc_pkg::ID_LEN ||
                      rmc_pkg::wanted_id(id_index_ff) != rx_byte) begin
                     mismatch_in = 1'b1;
                  end
                  if (id_index_ff < rmc_pkg::ID_MAX) begin
                     id_index_in = id_index_ff + 3'd1;
                  end
               end
            end
            MODE_FIELDS: begin
               if (rx_byte == rmc_pkg::CHAR_COMMA) begin
                  if (comma_ff == rmc_pkg::COMMA_COURSE) begin
                     mode_in        = MODE_HUNT;
                     id_index_in    = '0;
                     mismatch_in    = 1'b0;
                     comma_in       = '0;
                     pos_in         = '0;
                     res_valid      = 1'b1;
                     res.field_id   = rmc_pkg::FIELD_COURSE;
                     res.char_pos   = pos_ff;
                     res.done_res   = 1'b1;
                  end else begin
                     if (comma_ff < rmc_pkg::COMMA_MAX) begin
                        comma_in = comma_ff + 4'd1;
                     end
                     pos_in = '0;
                  end
               end else if (in_field && pos_ff < field_limit) begin
                  pos_in         = pos_ff + 4'd1;
                  res_valid      = 1'b1;
                  res.field_id   = field_code;
                  res.char_pos   = pos_ff;
                  res.char_value = rx_byte;
                  res.has_char   = 1'b1;
               end
            end
            default: begin
               mode_in     = MODE_HUNT;
               id_index_in = '0;
               mismatch_in = 1'b0;
               comma_in    = '0;
               pos_in      = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HUNT;
         id_index_ff <= '0;
         mismatch_ff <= 1'b0;
         comma_ff    <= '0;
         pos_ff      <= '0;
      end else if (byte_accept) begin
         mode_ff     <= mode_in;
         id_index_ff <= id_index_in;
         mismatch_ff <= mismatch_in;
         comma_ff    <= comma_in;
         pos_ff      <= pos_in;
      end
   end

endmodule

// ----- rtl/core/rmc_out_reg.sv -----
// rmc_out_reg: result holding register for the response channel
// depends on rmc_pkg

module rmc_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  rmc_pkg::result_type res,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output rmc_pkg::result_type rsp_data
);

   logic                valid_ff;
   rmc_pkg::result_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- rtl/core/nmea_rmc_field_extractor.sv -----
// nmea_rmc_field_extractor: top level, parser core and result register
// depends on rmc_pkg, rmc_parse_core, rmc_out_reg
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_rx_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_field_id, rsp_char_pos, rsp_char_value,
//                                            rsp_has_char, rsp_done_res
//
// one byte per cycle while req_ready is high; a result is formed combinationally from
// its byte and the parser state and appears in the cycle after it, from the result register
// reset clears the parser to hunting and empties the result register
// req_ready drops only while a result is held and rsp_ready is low

module nmea_rmc_field_extractor #(
   parameter int LAT_CHARS    = 10,
   parameter int LON_CHARS    = 11,
   parameter int SPEED_CHARS  = 5,
   parameter int COURSE_CHARS = 7
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_field_id,
   output logic [3:0] rsp_char_pos,
   output logic [7:0] rsp_char_value,
   output logic       rsp_has_char,
   output logic       rsp_done_res
);

   logic                byte_accept;
   logic                res_valid;
   rmc_pkg::result_type res;
   rmc_pkg::result_type rsp_data;

   assign req_ready   = !rsp_valid || rsp_ready;
   assign byte_accept = req_valid && req_ready;

   rmc_parse_core #(
      .LAT_CHARS   (LAT_CHARS),
      .LON_CHARS   (LON_CHARS),
      .SPEED_CHARS (SPEED_CHARS),
      .COURSE_CHARS(COURSE_CHARS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_accept(byte_accept),
      .rx_byte    (req_rx_byte),
      .res_valid  (res_valid),
      .res        (res)
   );

   rmc_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (byte_accept && res_valid),
      .res      (res),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   assign rsp_field_id   = rsp_data.field_id;
   assign rsp_char_pos   = rsp_data.char_pos;
   assign rsp_char_value = rsp_data.char_value;
   assign rsp_has_char   = rsp_data.has_char;
   assign rsp_done_res   = rsp_data.done_res;

endmodule
